>>> design/kwm_pkg.sv
// Shared types, codes and helpers for the timestamp k-way merge block.
package kwm_pkg;

  localparam int STREAMS            = 4;
  localparam int SIDX_W             = 2;
  localparam int ACT_W              = 3;
  localparam int DEFAULT_FIFO_DEPTH = 16;
  localparam int MAX_RESULTS        = 64;
  localparam int CNT_W              = 7;
  localparam int QDEPTH             = 2;
  localparam int QPW                = 1;
  localparam int QCW                = 2;

  localparam logic [ACT_W-1:0] ACT_RESET = 3'd4;

  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_CLOSE   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] ST_MERGED  = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_CLOSED  = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_CLOSE,
    OP_RESTART,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_APPLY,
    BS_SELECT,
    BS_EMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SIDX_W-1:0] stream_index;
    logic signed [63:0] event_time;
    logic [15:0]       instrument_index;
    logic [31:0]       payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SIDX_W-1:0] source_stream;
    logic signed [63:0] out_time;
    logic [15:0]       out_instrument;
    logic [31:0]       out_payload;
    logic              late;
    logic              all_done;
    logic              run_end;
  } out_item_t;

  typedef struct packed {
    logic signed [63:0] ev_time;
    logic [15:0]        ev_instr;
    logic [31:0]        ev_payload;
  } entry_t;

  typedef struct packed {
    op_t               op;
    logic [SIDX_W-1:0] stream;
    entry_t            ev;
  } q_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } lane_ctl_t;

  // Ordering key: signed timestamp, then instrument index.
  function automatic logic key_less(input entry_t a, input entry_t b);
    logic t_lt;
    logic t_eq;
    t_lt = $signed(a.ev_time) < $signed(b.ev_time);
    t_eq = a.ev_time == b.ev_time;
    return t_lt || (t_eq && (a.ev_instr < b.ev_instr));
  endfunction

endpackage

>>> design/kwm_lane.sv
// One stream's event FIFO: memory body with the head held in a register.
module kwm_lane #(
  parameter int FIFO_DEPTH = kwm_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  kwm_pkg::lane_ctl_t                 ctl,
  input  kwm_pkg::entry_t                    wr_data,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]    fill,
  output kwm_pkg::entry_t                    head
);
  import kwm_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int FW = $clog2(FIFO_DEPTH + 1);

  entry_t          mem [FIFO_DEPTH];
  entry_t          head_r;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic            to_mem;
  logic            refill;

  // Head is empty only when the whole lane is empty; the body holds the rest.
  assign to_mem = ctl.push && (fill_r != '0);
  assign refill = ctl.pop && (fill_r > FW'(1));

  always_comb begin
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (ctl.clear) begin
      rp_nxt   = '0;
      wp_nxt   = '0;
      fill_nxt = '0;
    end else begin
      if (to_mem) begin
        wp_nxt = (wp_r == PW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (refill) begin
        rp_nxt = (rp_r == PW'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (ctl.push) begin
        fill_nxt = fill_r + 1'b1;
      end else if (ctl.pop) begin
        fill_nxt = fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r   <= '0;
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (to_mem) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && (fill_r == '0)) begin
      head_r <= wr_data;
    end else if (refill) begin
      head_r <= mem[rp_r];
    end
  end

  assign fill = fill_r;
  assign head = head_r;

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> fill_r < FW'(FIFO_DEPTH))
    else $error("lane push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> fill_r != '0)
    else $error("lane pop while empty");
  a_push_pop_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop))
    else $error("lane push and pop together");
  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.pop && !ctl.clear) |=> fill_r == $past(fill_r) - 1'b1)
    else $error("lane fill not decremented");
`endif

endmodule

>>> design/kwm_front.sv
// Front end: accept requests, decode the command and queue them for the back end.
module kwm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kwm_pkg::in_item_t in_data,
  output logic              q_valid,
  output kwm_pkg::q_item_t  q_item,
  input  logic              q_pop
);
  import kwm_pkg::*;

  q_item_t          q_r [QDEPTH];
  q_item_t          dec;
  logic [QPW-1:0]   wp_r;
  logic [QPW-1:0]   rp_r;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             take;
  logic             give;

  always_comb begin
    dec.stream = in_data.stream_index;
    dec.ev.ev_time    = in_data.event_time;
    dec.ev.ev_instr   = in_data.instrument_index;
    dec.ev.ev_payload = in_data.payload;
    case (in_data.cmd)
      CMD_PUSH:    dec.op = OP_PUSH;
      CMD_CLOSE:   dec.op = OP_CLOSE;
      CMD_RESTART: dec.op = OP_RESTART;
      default:     dec.op = OP_NONE;
    endcase
  end

  assign in_ready = cnt_r != QCW'(QDEPTH);
  assign take     = in_valid && in_ready;
  assign q_valid  = cnt_r != '0;
  assign give     = q_pop && q_valid;
  assign q_item   = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (take && !give) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (give && !take) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (take) begin
        wp_r <= wp_r + 1'b1;
      end
      if (give) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_r[wp_r] <= dec;
    end
  end

`ifndef SYNTHESIS
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
  a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !give) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed an accepted request");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wp_r == rp_r))
    else $error("queue pointers apart while empty");
`endif

endmodule

>>> design/kwm_back.sv
// Back end: apply queued requests to the lanes and release merged events.
module kwm_back #(
  parameter int FIFO_DEPTH = kwm_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kwm_pkg::ACT_W-1:0]     cfg_wdata,
  input  logic                          q_valid,
  input  kwm_pkg::q_item_t              q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output kwm_pkg::out_item_t            out_data
);
  import kwm_pkg::*;

  localparam int FW = $clog2(FIFO_DEPTH + 1);

  back_state_t        state_r, state_nxt;
  q_item_t            cur_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SIDX_W-1:0]  win_r, win;
  logic [STREAMS-1:0] closed_r;
  logic signed [63:0] last_r;
  logic               emitted_r;
  logic [ACT_W-1:0]   act_r;
  logic               out_valid_r;
  out_item_t          out_r, out_nxt;

  lane_ctl_t          ctl [STREAMS];
  logic [FW-1:0]      fill [STREAMS];
  entry_t             head [STREAMS];

  logic [ACT_W-1:0]   act_n;
  logic [STREAMS-1:0] act_mask, nonempty, post_ne;
  logic               can_rel, any_ne, drained;
  logic               can_rel_post, any_ne_post, drained_post;
  logic               out_free;
  logic               closed_hit, full_hit, drop;
  logic               more;
  logic               load_out;
  logic               do_emit;
  logic               do_close;
  logic               do_restart;
  logic [CNT_W-1:0]   cnt_inc;

  genvar g;
  generate
    for (g = 0; g < STREAMS; g++) begin : g_lane
      kwm_lane #(
        .FIFO_DEPTH (FIFO_DEPTH)
      ) u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl[g]),
        .wr_data (cur_r.ev),
        .fill    (fill[g]),
        .head    (head[g])
      );
    end
  endgenerate

  // Clamp the stream count into 1..STREAMS.
  always_comb begin
    if (act_r == '0) begin
      act_n = ACT_W'(1);
    end else if (act_r > ACT_W'(STREAMS)) begin
      act_n = ACT_W'(STREAMS);
    end else begin
      act_n = act_r;
    end
  end

  always_comb begin
    for (int s = 0; s < STREAMS; s++) begin
      act_mask[s] = ACT_W'(s) < act_n;
      nonempty[s] = fill[s] != '0;
      post_ne[s]  = nonempty[s] && !((SIDX_W'(s) == win_r) && (fill[s] == FW'(1)));
    end
  end

  assign can_rel      = &(~act_mask | nonempty | closed_r);
  assign any_ne       = |(act_mask & nonempty);
  assign drained      = &(~act_mask | (closed_r & ~nonempty));
  assign can_rel_post = &(~act_mask | post_ne | closed_r);
  assign any_ne_post  = |(act_mask & post_ne);
  assign drained_post = &(~act_mask | (closed_r & ~post_ne));

  assign out_free = !out_valid_r || out_ready;
  assign cnt_inc  = cnt_r + 1'b1;
  assign more     = (cnt_r < CNT_W'(MAX_RESULTS)) && can_rel && any_ne;

  assign closed_hit = !act_mask[cur_r.stream] || closed_r[cur_r.stream];
  assign full_hit   = fill[cur_r.stream] == FW'(FIFO_DEPTH);
  assign drop       = (cur_r.op == OP_PUSH) && (closed_hit || full_hit);

  // Minimum head over the active, non-empty lanes: two-level tree, lower
  // index kept on a full tie.
  always_comb begin
    logic               v01, v23;
    logic [SIDX_W-1:0]  w01, w23;
    logic [STREAMS-1:0] cand;
    cand = act_mask & nonempty;
    w01  = (cand[0] && (!cand[1] || !key_less(head[1], head[0]))) ? SIDX_W'(0) : SIDX_W'(1);
    w23  = (cand[2] && (!cand[3] || !key_less(head[3], head[2]))) ? SIDX_W'(2) : SIDX_W'(3);
    v01  = cand[0] || cand[1];
    v23  = cand[2] || cand[3];
    win  = (v01 && (!v23 || !key_less(head[w23], head[w01]))) ? w01 : w23;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: begin
        if (q_valid) begin
          state_nxt = BS_APPLY;
        end
      end
      BS_APPLY: begin
        if (!drop || out_free) begin
          state_nxt = BS_SELECT;
        end
      end
      BS_SELECT: begin
        state_nxt = more ? BS_EMIT : BS_IDLE;
      end
      BS_EMIT: begin
        if (out_free) begin
          state_nxt = BS_SELECT;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop      = 1'b0;
    load_out   = 1'b0;
    do_emit    = 1'b0;
    do_close   = 1'b0;
    do_restart = 1'b0;
    out_nxt    = out_r;
    for (int s = 0; s < STREAMS; s++) begin
      ctl[s] = '0;
    end
    case (state_r)
      BS_IDLE: begin
        q_pop = q_valid;
      end
      BS_APPLY: begin
        case (cur_r.op)
          OP_PUSH: begin
            if (drop) begin
              load_out              = out_free;
              out_nxt.status        = closed_hit ? ST_CLOSED : ST_FULL;
              out_nxt.source_stream = cur_r.stream;
              out_nxt.out_time      = cur_r.ev.ev_time;
              out_nxt.out_instrument = cur_r.ev.ev_instr;
              out_nxt.out_payload   = cur_r.ev.ev_payload;
              out_nxt.late          = 1'b0;
              out_nxt.all_done      = drained;
              out_nxt.run_end       = !(can_rel && any_ne);
            end else begin
              ctl[cur_r.stream].push = 1'b1;
            end
          end
          OP_CLOSE:   do_close = act_mask[cur_r.stream];
          OP_RESTART: do_restart = 1'b1;
          default: ;
        endcase
        if (do_restart) begin
          for (int s = 0; s < STREAMS; s++) begin
            ctl[s].clear = 1'b1;
          end
        end
      end
      BS_EMIT: begin
        if (out_free) begin
          load_out              = 1'b1;
          do_emit               = 1'b1;
          ctl[win_r].pop        = 1'b1;
          out_nxt.status        = ST_MERGED;
          out_nxt.source_stream = win_r;
          out_nxt.out_time      = head[win_r].ev_time;
          out_nxt.out_instrument = head[win_r].ev_instr;
          out_nxt.out_payload   = head[win_r].ev_payload;
          out_nxt.late          = emitted_r &&
                                  ($signed(head[win_r].ev_time) < $signed(last_r));
          out_nxt.all_done      = drained_post;
          out_nxt.run_end       = !((cnt_inc < CNT_W'(MAX_RESULTS)) &&
                                    can_rel_post && any_ne_post);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      cnt_r       <= '0;
      closed_r    <= '0;
      emitted_r   <= 1'b0;
      act_r       <= ACT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        act_r <= cfg_wdata;
      end
      if (q_pop) begin
        cnt_r <= '0;
      end else if (load_out) begin
        cnt_r <= cnt_inc;
      end
      if (do_restart) begin
        closed_r  <= '0;
        emitted_r <= 1'b0;
      end else begin
        if (do_close) begin
          closed_r[cur_r.stream] <= 1'b1;
        end
        if (do_emit) begin
          emitted_r <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    if (state_r == BS_SELECT) begin
      win_r <= win;
    end
    if (do_emit) begin
      last_r <= head[win_r].ev_time;
    end
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_emit_from_live_lane: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_EMIT) |-> (nonempty[win_r] && act_mask[win_r]))
    else $error("emission from an empty or inactive lane");
  a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("result count beyond cap");
  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("result loaded over an untaken one");
  a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
    do_emit |=> (state_r == BS_SELECT) && (cnt_r == $past(cnt_inc)))
    else $error("emission did not advance the run");
`endif

endmodule

>>> design/timestamp_kway_merge_top.sv
// Top level of the timestamp-ordered k-way merge block.
//
//  channel  | ports                         | moves
//  ---------+-------------------------------+-------------------------------
//  input    | in_valid / in_ready / in_data | push, close or restart request
//  result   | out_valid / out_ready / out_data | merged event or drop report
//  config   | cfg_we / cfg_wdata            | active stream count
//
//  A request passes a two-entry queue, then back-end steps fetch, apply and release
//  check; apply waits for a free result slot when it reports a drop. Each event out
//  takes a four-way head compare, then a delivery step (held while a result is untaken)
//  that also reloads the lane head from its registered memory read.
//  Reset is synchronous and clears pointers, flags and control; event storage
//  is not cleared and needs no clearing pass.
//  A low out_ready holds the back end; the queue keeps taking requests until full.
module timestamp_kway_merge_top #(
  parameter int FIFO_DEPTH = kwm_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  kwm_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output kwm_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [kwm_pkg::ACT_W-1:0] cfg_wdata
);
  import kwm_pkg::*;

  // Decoded requests waiting for the back end.
  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  // Front end: accept and decode; blocked by a stalled result only once its queue is full.
  kwm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Back end: per-stream lanes, head compare and the result register.
  kwm_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end took a request from an empty queue");
  a_ready_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> in_ready && !out_valid)
    else $error("channels not idle after reset");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
`endif

endmodule
